// ===== hw/rtl/ksr_pkg.sv =====
// ----------------------------------------------------------------------------
// ksr_pkg
// Shared types and constants for the keyed slot registry: item formats,
// the stored entry format, the operation codes and the status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ksr_pkg;

   // table geometry
   localparam int SLOTS       = 64;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int EVENT_KINDS = 32;

   // operation codes
   localparam logic [2:0] OP_ADD         = 3'd0;
   localparam logic [2:0] OP_REMOVE      = 3'd1;
   localparam logic [2:0] OP_SUBSCRIBE   = 3'd2;
   localparam logic [2:0] OP_FIND_ID     = 3'd3;
   localparam logic [2:0] OP_FIND_HANDLE = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // request item
   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] key_id;
      logic [15:0] window_id;
      logic [15:0] parent_key;
      logic        parent_flag;
      logic [4:0]  kind;
      logic [63:0] handle;
   } req_type;

   // response item
   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  slot_index;
      logic [15:0] found_id;
      logic [15:0] found_window;
      logic [15:0] found_parent;
      logic        found_parent_flag;
      logic [3:0]  found_type;
      logic [63:0] found_handle;
      logic [31:0] found_mask;
      logic        is_container;
   } rsp_type;

   // one stored table entry
   typedef struct packed {
      logic [15:0] key;
      logic [15:0] window;
      logic [15:0] parent;
      logic        parent_flag;
      logic [3:0]  kind;
      logic [63:0] handle;
      logic [31:0] mask;
   } entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/keyed_slot_registry.sv =====
// ----------------------------------------------------------------------------
// keyed_slot_registry
// Slot table of entries keyed by a nonzero id: add, remove, subscribe,
// find by id and find by handle, one request at a time.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  ksr_pkg::req_type
//   rsp       out        rsp_valid/rsp_ready  ksr_pkg::rsp_type
//   csr       in         csr_write_en         container type code (4 bits)
//
// After acceptance the scan reads one entry per cycle over the table and
// compares each entry read; a drain step compares the last, a decide step
// sets the status and registers the response.
// Reset clears the valid bits, the container code and the sequencer; entry
// contents are not cleared. req_ready is low from acceptance until the
// response has been taken, and the response holds while rsp_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_slot_registry (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ksr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ksr_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_en,
   input  wire logic [3:0]       csr_write_data
);

   localparam int SW = ksr_pkg::SLOT_W;

   // sequencer codes
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   localparam logic [SW-1:0] LAST_IDX = SW'(ksr_pkg::SLOTS - 1);

   // entry memory
   ksr_pkg::entry_type mem [ksr_pkg::SLOTS];
   ksr_pkg::entry_type rd_data_ff;
   logic               mem_we;
   logic [SW-1:0]      mem_waddr;
   ksr_pkg::entry_type mem_wdata;

   // control and payload registers
   logic [2:0]         state_ff, state_in;
   logic [SW-1:0]      scan_idx_ff, scan_idx_in;
   logic [SW-1:0]      cmp_idx_ff;
   logic               cmp_live_ff;
   logic               hit_ff, hit_in;
   logic [SW-1:0]      hit_idx_ff, hit_idx_in;
   ksr_pkg::entry_type hit_data_ff, hit_data_in;
   logic               free_ff, free_in;
   logic [SW-1:0]      free_idx_ff, free_idx_in;
   ksr_pkg::req_type   req_ff, req_in;
   ksr_pkg::rsp_type   rsp_ff, rsp_in;
   logic [3:0]         ctype_ff;
   logic               valid_ff [ksr_pkg::SLOTS];

   logic               set_valid, clr_valid;
   logic [SW-1:0]      valid_addr;
   logic               match;
   ksr_pkg::entry_type upd;
   logic               kind_bad;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   // compare of the entry read in the previous cycle
   always_comb begin
      if (req_ff.opcode == ksr_pkg::OP_FIND_HANDLE) begin
         match = cmp_live_ff && valid_ff[cmp_idx_ff]
                 && (rd_data_ff.handle == req_ff.handle);
      end else begin
         match = cmp_live_ff && valid_ff[cmp_idx_ff]
                 && (rd_data_ff.key == req_ff.key_id);
      end
   end

   assign kind_bad = (32'(req_ff.kind) >= ksr_pkg::EVENT_KINDS);

   // sequencer and decision
   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_data_in = hit_data_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      req_in      = req_ff;
      rsp_in      = rsp_ff;
      mem_we      = 1'b0;
      mem_waddr   = free_idx_ff;
      mem_wdata   = hit_data_ff;
      set_valid   = 1'b0;
      clr_valid   = 1'b0;
      valid_addr  = hit_idx_ff;
      upd         = hit_data_ff;

      // lowest matching entry over the scan
      if (match && !hit_ff) begin
         hit_in      = 1'b1;
         hit_idx_in  = cmp_idx_ff;
         hit_data_in = rd_data_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               scan_idx_in = '0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            // lowest free slot, from the valid bits at the read address
            if (!valid_ff[scan_idx_ff] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = scan_idx_ff;
            end
            if (scan_idx_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            rsp_in   = '0;
            state_in = S_RESP;
            case (req_ff.opcode)
               ksr_pkg::OP_ADD: begin
                  if (req_ff.key_id == 16'd0) begin
                     rsp_in.status = ksr_pkg::ST_INVALID;
                  end else if (hit_ff) begin
                     rsp_in.status = ksr_pkg::ST_DUPLICATE;
                  end else if (!free_ff) begin
                     rsp_in.status = ksr_pkg::ST_FULL;
                  end else begin
                     upd.key         = req_ff.key_id;
                     upd.window      = req_ff.window_id;
                     upd.parent      = req_ff.parent_key;
                     upd.parent_flag = req_ff.parent_flag;
                     upd.kind        = req_ff.kind[3:0];
                     upd.handle      = req_ff.handle;
                     upd.mask        = '0;
                     mem_we          = 1'b1;
                     mem_waddr       = free_idx_ff;
                     mem_wdata       = upd;
                     set_valid       = 1'b1;
                     valid_addr      = free_idx_ff;
                     rsp_in.status   = ksr_pkg::ST_OK;
                  end
               end
               ksr_pkg::OP_REMOVE: begin
                  if (req_ff.key_id == 16'd0 || !hit_ff) begin
                     rsp_in.status = ksr_pkg::ST_NOT_FOUND;
                  end else begin
                     clr_valid     = 1'b1;
                     rsp_in.status = ksr_pkg::ST_OK;
                  end
               end
               ksr_pkg::OP_SUBSCRIBE: begin
                  if (req_ff.key_id == 16'd0 || kind_bad) begin
                     rsp_in.status = ksr_pkg::ST_INVALID;
                  end else if (!hit_ff) begin
                     rsp_in.status = ksr_pkg::ST_NOT_FOUND;
                  end else begin
                     upd.mask      = hit_data_ff.mask | (32'd1 << req_ff.kind);
                     mem_we        = 1'b1;
                     mem_waddr     = hit_idx_ff;
                     mem_wdata     = upd;
                     rsp_in.status = ksr_pkg::ST_OK;
                  end
               end
               ksr_pkg::OP_FIND_ID: begin
                  if (req_ff.key_id == 16'd0) begin
                     rsp_in.status = ksr_pkg::ST_INVALID;
                  end else if (!hit_ff) begin
                     rsp_in.status = ksr_pkg::ST_NOT_FOUND;
                  end else begin
                     rsp_in.status = ksr_pkg::ST_OK;
                  end
               end
               ksr_pkg::OP_FIND_HANDLE: begin
                  if (req_ff.handle == 64'd0) begin
                     rsp_in.status = ksr_pkg::ST_INVALID;
                  end else if (!hit_ff) begin
                     rsp_in.status = ksr_pkg::ST_NOT_FOUND;
                  end else begin
                     rsp_in.status = ksr_pkg::ST_OK;
                  end
               end
               default: begin
                  rsp_in.status = ksr_pkg::ST_INVALID;
               end
            endcase
            // entry contents only on success
            if (rsp_in.status == ksr_pkg::ST_OK) begin
               rsp_in.slot_index = (req_ff.opcode == ksr_pkg::OP_ADD)
                                   ? 6'(free_idx_ff) : 6'(hit_idx_ff);
               rsp_in.found_id          = upd.key;
               rsp_in.found_window      = upd.window;
               rsp_in.found_parent      = upd.parent;
               rsp_in.found_parent_flag = upd.parent_flag;
               rsp_in.found_type        = upd.kind;
               rsp_in.found_handle      = upd.handle;
               rsp_in.found_mask        = upd.mask;
               rsp_in.is_container      = (upd.kind == ctype_ff);
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[scan_idx_ff];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '{default: 1'b0};
      end else if (set_valid) begin
         valid_ff[valid_addr] <= 1'b1;
      end else if (clr_valid) begin
         valid_ff[valid_addr] <= 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cmp_live_ff <= 1'b0;
         ctype_ff    <= 4'd0;
      end else begin
         state_ff    <= state_in;
         cmp_live_ff <= (state_ff == S_SCAN);
         if (csr_write_en) begin
            ctype_ff <= csr_write_data;
         end
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= scan_idx_ff;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_data_ff <= hit_data_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed slot registry. A driver process offers
// requests from a queue of pending items. A mirror of the slot table in the
// bench predicts the response of each accepted request. A monitor process
// checks every response, field by field, against the oldest prediction.
// A directed run covers the corner cases. Random phases follow with mixed,
// table-filling and draining traffic under several container codes.
// ----------------------------------------------------------------------------

module tb;

   localparam int SW = ksr_pkg::SLOT_W;

   // opcodes the block has no operation for
   localparam logic [2:0] OP_SPARE_A = 3'd5;
   localparam logic [2:0] OP_SPARE_B = 3'd6;
   localparam logic [2:0] OP_SPARE_C = 3'd7;

   // random traffic profiles
   localparam int MODE_MIX   = 0;
   localparam int MODE_FILL  = 1;
   localparam int MODE_DRAIN = 2;

   localparam int LONG_HOLD   = 400;
   localparam int STUCK_LIMIT = 3000;
   localparam int SETTLE      = 80;   // a little over one table scan

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   ksr_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   ksr_pkg::rsp_type rsp_data;
   logic    csr_write_en;
   logic [3:0] csr_write_data;

   // mirror of the table and the container code
   bit                 slot_live [ksr_pkg::SLOTS];
   ksr_pkg::entry_type slot_entry [ksr_pkg::SLOTS];
   logic [3:0]         container_code;

   ksr_pkg::req_type pending [$];
   ksr_pkg::rsp_type due_responses [$];
   logic [63:0] tag_pool [8];
   bit          quiet;
   int          mismatches;
   int          send_gap;
   int          stall_left;
   int          taken;
   int          stuck;

   keyed_slot_registry dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
   endtask

   // lowest live slot holding this id, or -1
   function automatic int slot_of_key(logic [15:0] key);
      int found;
      found = -1;
      for (int s = ksr_pkg::SLOTS - 1; s >= 0; s--)
         if (slot_live[SW'(s)] && slot_entry[SW'(s)].key == key) found = s;
      return found;
   endfunction

   // apply one request to the mirror table and return its response
   function automatic ksr_pkg::rsp_type apply_registry_op(ksr_pkg::req_type r);
      ksr_pkg::rsp_type res;
      int hit;
      int spare;
      logic [SW-1:0] at;
      res = '0;
      hit = -1;
      spare = -1;
      case (r.opcode)
         ksr_pkg::OP_ADD: begin
            if (r.key_id == '0) res.status = ksr_pkg::ST_INVALID;
            else if (slot_of_key(r.key_id) >= 0) res.status = ksr_pkg::ST_DUPLICATE;
            else begin
               for (int s = ksr_pkg::SLOTS - 1; s >= 0; s--)
                  if (!slot_live[SW'(s)]) spare = s;
               if (spare < 0) res.status = ksr_pkg::ST_FULL;
               else begin
                  at = SW'(spare);
                  slot_live[at] = 1'b1;
                  slot_entry[at].key         = r.key_id;
                  slot_entry[at].window      = r.window_id;
                  slot_entry[at].parent      = r.parent_key;
                  slot_entry[at].parent_flag = r.parent_flag;
                  slot_entry[at].kind        = r.kind[3:0];
                  slot_entry[at].handle      = r.handle;
                  slot_entry[at].mask        = '0;
                  hit = spare;
               end
            end
         end
         ksr_pkg::OP_REMOVE: begin
            if (r.key_id != '0) hit = slot_of_key(r.key_id);
            if (hit < 0) res.status = ksr_pkg::ST_NOT_FOUND;
         end
         ksr_pkg::OP_SUBSCRIBE: begin
            if (r.key_id == '0 || int'(r.kind) >= ksr_pkg::EVENT_KINDS)
               res.status = ksr_pkg::ST_INVALID;
            else begin
               hit = slot_of_key(r.key_id);
               if (hit < 0) res.status = ksr_pkg::ST_NOT_FOUND;
               else slot_entry[SW'(hit)].mask[r.kind] = 1'b1;
            end
         end
         ksr_pkg::OP_FIND_ID: begin
            if (r.key_id == '0) res.status = ksr_pkg::ST_INVALID;
            else begin
               hit = slot_of_key(r.key_id);
               if (hit < 0) res.status = ksr_pkg::ST_NOT_FOUND;
            end
         end
         ksr_pkg::OP_FIND_HANDLE: begin
            if (r.handle == '0) res.status = ksr_pkg::ST_INVALID;
            else begin
               for (int s = ksr_pkg::SLOTS - 1; s >= 0; s--)
                  if (slot_live[SW'(s)] && slot_entry[SW'(s)].handle == r.handle) hit = s;
               if (hit < 0) res.status = ksr_pkg::ST_NOT_FOUND;
            end
         end
         default: res.status = ksr_pkg::ST_INVALID;
      endcase
      if (hit >= 0) begin
         at = SW'(hit);
         res.status            = ksr_pkg::ST_OK;
         res.slot_index        = 6'(hit);
         res.found_id          = slot_entry[at].key;
         res.found_window      = slot_entry[at].window;
         res.found_parent      = slot_entry[at].parent;
         res.found_parent_flag = slot_entry[at].parent_flag;
         res.found_type        = slot_entry[at].kind;
         res.found_handle      = slot_entry[at].handle;
         res.found_mask        = slot_entry[at].mask;
         res.is_container      = (slot_entry[at].kind == container_code);
         // remove reports the entry, then frees it
         if (r.opcode == ksr_pkg::OP_REMOVE) slot_live[at] = 1'b0;
      end
      return res;
   endfunction

   // idle stretch: mostly short, now and then long
   function automatic int idle_length();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 20);
      return $urandom_range(40, 150);
   endfunction

   function automatic ksr_pkg::req_type random_request(int mode);
      ksr_pkg::req_type r;
      int pick;
      int pool;
      r = '0;
      pick = $urandom_range(99);
      case (mode)
         MODE_FILL: begin
            pool = 150;
            if (pick < 75) r.opcode = ksr_pkg::OP_ADD;
            else if (pick < 82) r.opcode = ksr_pkg::OP_REMOVE;
            else if (pick < 88) r.opcode = ksr_pkg::OP_SUBSCRIBE;
            else if (pick < 93) r.opcode = ksr_pkg::OP_FIND_ID;
            else if (pick < 98) r.opcode = ksr_pkg::OP_FIND_HANDLE;
            else r.opcode = OP_SPARE_A;
         end
         MODE_DRAIN: begin
            pool = 150;
            if (pick < 10) r.opcode = ksr_pkg::OP_ADD;
            else if (pick < 65) r.opcode = ksr_pkg::OP_REMOVE;
            else if (pick < 75) r.opcode = ksr_pkg::OP_SUBSCRIBE;
            else if (pick < 85) r.opcode = ksr_pkg::OP_FIND_ID;
            else if (pick < 97) r.opcode = ksr_pkg::OP_FIND_HANDLE;
            else r.opcode = OP_SPARE_B;
         end
         default: begin
            pool = 48;
            if (pick < 30) r.opcode = ksr_pkg::OP_ADD;
            else if (pick < 48) r.opcode = ksr_pkg::OP_REMOVE;
            else if (pick < 68) r.opcode = ksr_pkg::OP_SUBSCRIBE;
            else if (pick < 83) r.opcode = ksr_pkg::OP_FIND_ID;
            else if (pick < 95) r.opcode = ksr_pkg::OP_FIND_HANDLE;
            else if (pick < 97) r.opcode = OP_SPARE_A;
            else if (pick < 99) r.opcode = OP_SPARE_B;
            else r.opcode = OP_SPARE_C;
         end
      endcase
      // ids from a small pool so that hits and duplicates are common
      pick = $urandom_range(99);
      if (pick < 5) r.key_id = '0;
      else if (pick < 8) r.key_id = 16'hFFFF;
      else if (pick < 12) r.key_id = 16'($urandom);
      else r.key_id = 16'($urandom_range(1, pool));
      r.window_id   = 16'($urandom);
      r.parent_key  = 16'($urandom);
      r.parent_flag = 1'($urandom);
      r.kind        = 5'($urandom_range(0, 31));
      // handles shared between entries now and then
      pick = $urandom_range(99);
      if (pick < 10) r.handle = '0;
      else if (pick < 60) r.handle = tag_pool[3'($urandom_range(0, 7))];
      else r.handle = {32'($urandom), 32'($urandom)};
      return r;
   endfunction

   task automatic queue_op(logic [2:0] op, logic [15:0] id, logic [4:0] kind,
                           logic [63:0] h, logic [15:0] win, logic [15:0] par,
                           logic pflag);
      ksr_pkg::req_type r;
      r.opcode      = op;
      r.key_id      = id;
      r.window_id   = win;
      r.parent_key  = par;
      r.parent_flag = pflag;
      r.kind        = kind;
      r.handle      = h;
      pending.push_back(r);
   endtask

   // sampled on the falling edge, after every clocked update has settled
   task automatic wait_drained();
      do @(negedge clock);
      while (pending.size() != 0 || req_valid || due_responses.size() != 0);
   endtask

   task automatic write_container_code(logic [3:0] code);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= code;
      container_code = code;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (req_valid && !req_ready) begin
         // hold the offered item until it is taken
      end else begin
         if (req_valid) due_responses.push_back(apply_registry_op(req_data));
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending.size() != 0) begin
            req_data  <= pending.pop_front();
            req_valid <= 1'b1;
            send_gap = (quiet || $urandom_range(99) < 45) ? 0 : idle_length();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and ready generation
   always @(posedge clock) begin
      ksr_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         taken = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            taken++;
            if (due_responses.size() == 0) begin
               note_mismatch("response with nothing due", 64'(rsp_data.status), '0);
            end else begin
               want = due_responses.pop_front();
               if (rsp_data.status !== want.status)
                  note_mismatch("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.slot_index !== want.slot_index)
                  note_mismatch("slot_index", 64'(rsp_data.slot_index),
                                64'(want.slot_index));
               if (rsp_data.found_id !== want.found_id)
                  note_mismatch("found_id", 64'(rsp_data.found_id), 64'(want.found_id));
               if (rsp_data.found_window !== want.found_window)
                  note_mismatch("found_window", 64'(rsp_data.found_window),
                                64'(want.found_window));
               if (rsp_data.found_parent !== want.found_parent)
                  note_mismatch("found_parent", 64'(rsp_data.found_parent),
                                64'(want.found_parent));
               if (rsp_data.found_parent_flag !== want.found_parent_flag)
                  note_mismatch("found_parent_flag", 64'(rsp_data.found_parent_flag),
                                64'(want.found_parent_flag));
               if (rsp_data.found_type !== want.found_type)
                  note_mismatch("found_type", 64'(rsp_data.found_type),
                                64'(want.found_type));
               if (rsp_data.found_handle !== want.found_handle)
                  note_mismatch("found_handle", rsp_data.found_handle, want.found_handle);
               if (rsp_data.found_mask !== want.found_mask)
                  note_mismatch("found_mask", 64'(rsp_data.found_mask),
                                64'(want.found_mask));
               if (rsp_data.is_container !== want.is_container)
                  note_mismatch("is_container", 64'(rsp_data.is_container),
                                64'(want.is_container));
            end
            // long back-pressure: the sender keeps offering meanwhile
            if (taken == 100 || taken == 380) stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(99) < 30) begin
            stall_left = idle_length() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         stuck = 0;
      end else begin
         stuck++;
         if (stuck >= STUCK_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      container_code = '0;
      quiet          = 1'b0;
      mismatches     = 0;
      slot_live      = '{default: 1'b0};
      tag_pool[0] = '1;
      tag_pool[1] = 64'd1;
      tag_pool[2] = 64'h8000_0000_0000_0000;
      for (int i = 3; i < 8; i++) tag_pool[3'(i)] = {32'($urandom), 32'($urandom)};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners, container code still at its reset value
      queue_op(ksr_pkg::OP_FIND_ID,     16'd0,    5'd0,  64'd1,    16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_ADD,         16'd0,    5'd3,  64'd1,    16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_REMOVE,      16'd5,    5'd0,  64'd0,    16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_ADD,         16'd1,    5'd0,  '1,       16'hFFFF, 16'd0,    1'b1);
      queue_op(ksr_pkg::OP_ADD,         16'hFFFF, 5'd31, 64'd1,    16'd0,    16'hFFFF, 1'b0);
      queue_op(ksr_pkg::OP_ADD,         16'd1,    5'd2,  64'd9,    16'd7,    16'd7,    1'b0);
      queue_op(ksr_pkg::OP_ADD,         16'd2,    5'd16, '1,       16'h5A5A, 16'hA5A5, 1'b1);
      queue_op(ksr_pkg::OP_SUBSCRIBE,   16'd1,    5'd0,  64'd0,    16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_SUBSCRIBE,   16'd1,    5'd31, 64'd0,    16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_SUBSCRIBE,   16'd0,    5'd4,  64'd0,    16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_SUBSCRIBE,   16'd3,    5'd4,  64'd0,    16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_FIND_ID,     16'hFFFF, 5'd0,  64'd0,    16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_FIND_ID,     16'd7,    5'd0,  64'd0,    16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_FIND_HANDLE, 16'd1,    5'd0,  64'd0,    16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_FIND_HANDLE, 16'd0,    5'd0,  '1,       16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_FIND_HANDLE, 16'd0,    5'd0,  64'h1234, 16'd0,    16'd0,    1'b0);
      queue_op(OP_SPARE_A,              16'd1,    5'd0,  '1,       16'd0,    16'd0,    1'b0);
      queue_op(OP_SPARE_B,              16'd1,    5'd0,  '1,       16'd0,    16'd0,    1'b0);
      queue_op(OP_SPARE_C,              16'd1,    5'd0,  '1,       16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_REMOVE,      16'd1,    5'd0,  64'd0,    16'd0,    16'd0,    1'b0);
      // the shared handle now resolves to the next live slot
      queue_op(ksr_pkg::OP_FIND_HANDLE, 16'd0,    5'd0,  '1,       16'd0,    16'd0,    1'b0);
      // the freed lowest slot is taken again
      queue_op(ksr_pkg::OP_ADD,         16'd3,    5'd15, 64'd2,    16'd1,    16'd1,    1'b1);
      queue_op(ksr_pkg::OP_REMOVE,      16'd0,    5'd0,  64'd0,    16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_REMOVE,      16'hFFFF, 5'd0,  64'd0,    16'd0,    16'd0,    1'b0);
      queue_op(ksr_pkg::OP_FIND_ID,     16'hFFFF, 5'd0,  64'd0,    16'd0,    16'd0,    1'b0);
      wait_drained();

      // mixed traffic, top container code
      write_container_code(4'hF);
      repeat (120) pending.push_back(random_request(MODE_MIX));
      wait_drained();

      // fill the table until adds report full, first without any idling
      write_container_code(4'($urandom_range(1, 14)));
      quiet = 1'b1;
      repeat (60) pending.push_back(random_request(MODE_FILL));
      wait_drained();
      quiet = 1'b0;
      repeat (100) pending.push_back(random_request(MODE_FILL));
      wait_drained();

      // drain, container code back to zero
      write_container_code(4'h0);
      repeat (100) pending.push_back(random_request(MODE_DRAIN));
      wait_drained();

      write_container_code(4'($urandom_range(0, 15)));
      repeat (120) pending.push_back(random_request(MODE_MIX));
      wait_drained();

      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ksr_pkg.sv
hw/rtl/keyed_slot_registry.sv
dv/tb.sv
